### hdl/trr_pkg.sv
// Types and constants shared by the TFTP read receiver modules.
// No dependencies; compiled first.
package trr_pkg;

    localparam logic [15:0] OP_DATA    = 16'd3;
    localparam logic [15:0] OP_ERROR   = 16'd5;
    localparam logic [15:0] HDR_BYTES  = 16'd4;
    localparam logic [15:0] FULL_BLOCK = 16'd512;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DONE     = 2'd1,
        EV_ERROR    = 2'd2,
        EV_OVERFLOW = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        CFG_REMOTE_ADDR = 2'd0,
        CFG_SERVER_PORT = 2'd1,
        CFG_BUFFER_SIZE = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_REQUESTED = 4'b0010,
        PH_RECEIVING = 4'b0100,
        PH_ERROR     = 4'b1000
    } t_phase;

    // item after classification by the front end
    typedef struct packed {
        logic        is_start;
        logic        addr_ok;
        logic        len_ok;
        logic        op_err;
        logic        op_data;
        logic [15:0] src_port;
        logic [15:0] blk;
        logic [15:0] payload;
    } t_cls;

    typedef struct packed {
        logic        send_request;
        logic        send_ack;
        logic [15:0] ack_block;
        logic [31:0] store_offset;
        logic [15:0] store_len;
        t_event      event_res;
        logic [31:0] bytes_received;
        logic [15:0] peer_port;
    } t_result;

endpackage

### hdl/trr_in_if.sv
// Input item channel of the TFTP read receiver.
// No dependencies.
interface trr_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] datagram_len;
    logic [15:0] opcode;
    logic [15:0] block_number;

    modport source (output valid, output req_type, output src_addr, output src_port,
                    output datagram_len, output opcode, output block_number,
                    input ready);
    modport sink (input valid, input req_type, input src_addr, input src_port,
                  input datagram_len, input opcode, input block_number,
                  output ready);
endinterface

### hdl/trr_out_if.sv
// Result item channel of the TFTP read receiver.
// No dependencies.
interface trr_out_if;
    logic        valid;
    logic        ready;
    logic        send_request;
    logic        send_ack;
    logic [15:0] ack_block;
    logic [31:0] store_offset;
    logic [15:0] store_len;
    logic [1:0]  event_res;
    logic [31:0] bytes_received;
    logic [15:0] peer_port;

    modport source (output valid, output send_request, output send_ack, output ack_block,
                    output store_offset, output store_len, output event_res,
                    output bytes_received, output peer_port, input ready);
    modport sink (input valid, input send_request, input send_ack, input ack_block,
                  input store_offset, input store_len, input event_res,
                  input bytes_received, input peer_port, output ready);
endinterface

### hdl/trr_cfg_if.sv
// Register write channel of the TFTP read receiver.
// No dependencies.
interface trr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [31:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

### hdl/trr_front.sv
// Front end: takes input items and classifies them (source, length, opcode).
// Depends on trr_pkg and trr_in_if.
module trr_front (
    trr_in_if.sink             i_in,
    input  logic [31:0]        i_remote_addr,
    input  logic               i_q_ready,
    output logic               o_q_push,
    output trr_pkg::t_cls      o_q_item
);

    assign i_in.ready = i_q_ready;
    assign o_q_push   = i_in.valid && i_q_ready;

    always_comb begin
        o_q_item.is_start = !i_in.req_type;
        o_q_item.addr_ok  = i_in.src_addr == i_remote_addr;
        o_q_item.len_ok   = i_in.datagram_len >= trr_pkg::HDR_BYTES;
        o_q_item.op_err   = i_in.opcode == trr_pkg::OP_ERROR;
        o_q_item.op_data  = i_in.opcode == trr_pkg::OP_DATA;
        o_q_item.src_port = i_in.src_port;
        o_q_item.blk      = i_in.block_number;
        // only meaningful when len_ok
        o_q_item.payload  = i_in.datagram_len - trr_pkg::HDR_BYTES;
    end

endmodule

### hdl/trr_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on trr_pkg.
module trr_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trr_pkg::t_cls i_item,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output trr_pkg::t_cls o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    trr_pkg::t_cls   r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            push_ok;
    logic            pop_ok;

    assign o_ready = r_count != FULL_CNT;
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push_ok) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### hdl/trr_back.sv
// Back end: transfer state (phase, block, byte count, port) and result register.
// Depends on trr_pkg and trr_out_if.
module trr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_buffer_size,
    input  logic          i_q_valid,
    input  trr_pkg::t_cls i_q_item,
    output logic          o_q_pop,
    trr_out_if.source     o_out
);

    trr_pkg::t_phase  r_phase, n_phase;
    logic [15:0]      r_exp, n_exp;
    logic [31:0]      r_bytes, n_bytes;
    logic [15:0]      r_port, n_port;
    logic             r_valid;
    trr_pkg::t_result r_res, n_res;

    logic [31:0]      space;
    logic             clip;
    logic [15:0]      take_len;
    logic             port_ok;
    logic             live;

    assign o_q_pop = i_q_valid && (!r_valid || o_out.ready);

    // buffer space left, zero when the size was lowered below the count
    assign space    = (r_bytes > i_buffer_size) ? 32'd0 : i_buffer_size - r_bytes;
    assign clip     = {16'd0, i_q_item.payload} > space;
    assign take_len = clip ? space[15:0] : i_q_item.payload;
    assign live     = (r_phase == trr_pkg::PH_REQUESTED) || (r_phase == trr_pkg::PH_RECEIVING);
    assign port_ok  = (r_phase == trr_pkg::PH_REQUESTED) || (i_q_item.src_port == r_port);

    always_comb begin
        n_phase = r_phase;
        n_exp   = r_exp;
        n_bytes = r_bytes;
        n_port  = r_port;
        n_res.send_request = 1'b0;
        n_res.send_ack     = 1'b0;
        n_res.ack_block    = 16'd0;
        n_res.store_offset = 32'd0;
        n_res.store_len    = 16'd0;
        n_res.event_res    = trr_pkg::EV_NONE;
        if (i_q_item.is_start) begin
            n_res.send_request = 1'b1;
            n_phase = trr_pkg::PH_REQUESTED;
            n_exp   = 16'd1;
            n_bytes = 32'd0;
            n_port  = 16'd0;
        end else if (live && i_q_item.addr_ok) begin
            // first datagram latches the server transfer port
            if (r_phase == trr_pkg::PH_REQUESTED) begin
                n_port  = i_q_item.src_port;
                n_phase = trr_pkg::PH_RECEIVING;
            end
            if (port_ok && i_q_item.len_ok) begin
                if (i_q_item.op_err) begin
                    n_res.event_res = trr_pkg::EV_ERROR;
                    n_phase = trr_pkg::PH_ERROR;
                end else if (i_q_item.op_data) begin
                    if (i_q_item.blk != r_exp) begin
                        // duplicate of the previous block: ack it again
                        if (i_q_item.blk == r_exp - 16'd1) begin
                            n_res.send_ack  = 1'b1;
                            n_res.ack_block = i_q_item.blk;
                        end
                    end else begin
                        n_res.send_ack     = 1'b1;
                        n_res.ack_block    = r_exp;
                        n_res.store_offset = r_bytes;
                        n_res.store_len    = take_len;
                        n_bytes = r_bytes + {16'd0, take_len};
                        n_exp   = r_exp + 16'd1;
                        if (clip) begin
                            n_res.event_res = trr_pkg::EV_OVERFLOW;
                            n_phase = trr_pkg::PH_ERROR;
                        end else if (take_len < trr_pkg::FULL_BLOCK) begin
                            n_res.event_res = trr_pkg::EV_DONE;
                            n_phase = trr_pkg::PH_IDLE;
                        end
                    end
                end
            end
        end
        n_res.bytes_received = n_bytes;
        n_res.peer_port      = n_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= trr_pkg::PH_IDLE;
            r_exp   <= 16'd0;
            r_bytes <= 32'd0;
            r_port  <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase <= n_phase;
                r_exp   <= n_exp;
                r_bytes <= n_bytes;
                r_port  <= n_port;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.send_request   = r_res.send_request;
    assign o_out.send_ack       = r_res.send_ack;
    assign o_out.ack_block      = r_res.ack_block;
    assign o_out.store_offset   = r_res.store_offset;
    assign o_out.store_len      = r_res.store_len;
    assign o_out.event_res      = r_res.event_res;
    assign o_out.bytes_received = r_res.bytes_received;
    assign o_out.peer_port      = r_res.peer_port;

endmodule

### hdl/tftp_read_receiver.sv
// TFTP read receiver top level: register port, front end, queue, back end.
// Depends on trr_pkg, the channel interfaces, trr_front, trr_queue and trr_back.
//
// Usage:
//   i_cfg  : register writes (0 remote address, 1 server port, 2 buffer size).
//            Always ready; write only while no item is in flight.
//   i_in   : one item per start command or received datagram header.
//   o_out  : exactly one result item per input item, in order.
// Timing:
//   An accepted item is written into the queue, then popped by the back end
//   into the result register, which shows it. One item per cycle is
//   sustained while o_out.ready stays high; the back end's per-item state
//   update is the loop that sets this rate.
// Stalls:
//   When o_out.ready is low the result register holds; the queue absorbs up
//   to QUEUE_DEPTH more items before i_in.ready drops.
// Reset:
//   Synchronous, active low. Clears config and state registers, phase to idle, queue empty.
module tftp_read_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    trr_cfg_if.sink   i_cfg,
    trr_in_if.sink    i_in,
    trr_out_if.source o_out
);

    logic [31:0]   r_remote_addr;
    logic [31:0]   r_buffer_size;
    logic          q_push;
    logic          q_ready;
    logic          q_pop;
    logic          q_valid;
    trr_pkg::t_cls q_in_item;
    trr_pkg::t_cls q_out_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote_addr <= 32'd0;
            r_buffer_size <= 32'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                trr_pkg::CFG_REMOTE_ADDR: r_remote_addr <= i_cfg.data;
                trr_pkg::CFG_BUFFER_SIZE: r_buffer_size <= i_cfg.data;
                // server port only matters to request formatting outside
                trr_pkg::CFG_SERVER_PORT: ;
                default: ;
            endcase
        end
    end

    trr_front u_front (
        .i_in          (i_in),
        .i_remote_addr (r_remote_addr),
        .i_q_ready     (q_ready),
        .o_q_push      (q_push),
        .o_q_item      (q_in_item)
    );

    trr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    trr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_buffer_size (r_buffer_size),
        .i_q_valid     (q_valid),
        .i_q_item      (q_out_item),
        .o_q_pop       (q_pop),
        .o_out         (o_out)
    );

    // a start result carries nothing else
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.send_request) |->
            (!o_out.send_ack && o_out.store_len == 16'd0 &&
             o_out.event_res == trr_pkg::EV_NONE && o_out.bytes_received == 32'd0))
        else $error("start result carries extra fields");

    // stored payload is always acknowledged
    a_store_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.store_len != 16'd0) |-> o_out.send_ack)
        else $error("payload stored without ack");

    // overflow result ends exactly at the updated byte count
    a_overflow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_res == trr_pkg::EV_OVERFLOW) |->
            (o_out.bytes_received == o_out.store_offset + {16'd0, o_out.store_len}))
        else $error("byte count mismatch on overflow");

    // an item is only taken when the queue has room
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (q_push && q_ready))
        else $error("item accepted without queue room");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for tftp_read_receiver: directed and random transfers.
// Depends on trr_pkg, trr_in_if, trr_out_if, trr_cfg_if and the receiver RTL.
module testbench;

    localparam int HOLD_CYCLES = 60;
    localparam int TOTAL_ITEMS = 1400;

    typedef struct packed {
        logic        req_type;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] datagram_len;
        logic [15:0] opcode;
        logic [15:0] block_number;
    } t_rx_item;

    // Tracks the transfer state and holds the results still due from the block.
    class transfer_scoreboard;
        trr_pkg::t_result due_q[$];
        int               errors = 0;
        int               reported = 0;
        logic [31:0]      remote_addr = '0;
        logic [15:0]      server_port = '0;
        logic [31:0]      buffer_size = '0;
        trr_pkg::t_phase  phase = trr_pkg::PH_IDLE;
        logic [15:0]      next_blk = '0;
        logic [31:0]      byte_cnt = '0;
        logic [15:0]      peer = '0;

        function void set_reg(trr_pkg::t_cfg_reg idx, logic [31:0] data);
            case (idx)
                trr_pkg::CFG_REMOTE_ADDR: remote_addr = data;
                trr_pkg::CFG_SERVER_PORT: server_port = data[15:0];
                trr_pkg::CFG_BUFFER_SIZE: buffer_size = data;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        function string show(trr_pkg::t_result r);
            return $sformatf("req=%0d ack=%0d blk=%0d off=%0d len=%0d ev=%0d bytes=%0d port=%0d",
                             r.send_request, r.send_ack, r.ack_block, r.store_offset,
                             r.store_len, r.event_res, r.bytes_received, r.peer_port);
        endfunction

        // Predicts the result of one accepted item.
        function void note_item(t_rx_item it);
            trr_pkg::t_result r;
            logic [31:0]      payload;
            logic [31:0]      space;
            logic [31:0]      take;
            logic [15:0]      prev;
            bit               go;
            r = '0;
            r.event_res = trr_pkg::EV_NONE;
            go = 1'b1;
            if (it.req_type == 1'b0) begin
                r.send_request = 1'b1;
                phase = trr_pkg::PH_REQUESTED;
                next_blk = 16'd1;
                byte_cnt = '0;
                peer = '0;
                go = 1'b0;
            end
            if (go && phase != trr_pkg::PH_REQUESTED && phase != trr_pkg::PH_RECEIVING)
                go = 1'b0;
            if (go && it.src_addr != remote_addr)
                go = 1'b0;
            if (go) begin
                // first datagram after the request fixes the server's transfer port
                if (phase == trr_pkg::PH_REQUESTED) begin
                    peer = it.src_port;
                    phase = trr_pkg::PH_RECEIVING;
                end else if (it.src_port != peer) begin
                    go = 1'b0;
                end
            end
            if (go && it.datagram_len < trr_pkg::HDR_BYTES)
                go = 1'b0;
            if (go && it.opcode == trr_pkg::OP_ERROR) begin
                r.event_res = trr_pkg::EV_ERROR;
                phase = trr_pkg::PH_ERROR;
                go = 1'b0;
            end
            if (go && it.opcode != trr_pkg::OP_DATA)
                go = 1'b0;
            if (go && it.block_number != next_blk) begin
                prev = next_blk - 16'd1;
                if (prev == it.block_number) begin
                    r.send_ack = 1'b1;
                    r.ack_block = prev;
                end
                go = 1'b0;
            end
            if (go) begin
                payload = {16'd0, it.datagram_len - trr_pkg::HDR_BYTES};
                space = (byte_cnt > buffer_size) ? 32'd0 : buffer_size - byte_cnt;
                take = (payload > space) ? space : payload;
                r.store_offset = byte_cnt;
                r.store_len = take[15:0];
                byte_cnt = byte_cnt + take;
                r.send_ack = 1'b1;
                r.ack_block = next_blk;
                next_blk = next_blk + 16'd1;
                if (take != payload) begin
                    r.event_res = trr_pkg::EV_OVERFLOW;
                    phase = trr_pkg::PH_ERROR;
                end else if (take < trr_pkg::FULL_BLOCK) begin
                    r.event_res = trr_pkg::EV_DONE;
                    phase = trr_pkg::PH_IDLE;
                end
            end
            r.bytes_received = byte_cnt;
            r.peer_port = peer;
            due_q.push_back(r);
        endfunction

        function void check_result(trr_pkg::t_result got);
            trr_pkg::t_result want;
            bit               bad;
            if (due_q.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result: %s", show(got));
                end
                return;
            end
            want = due_q.pop_front();
            bad = (got.send_request !== want.send_request) || (got.send_ack !== want.send_ack)
                || (got.ack_block !== want.ack_block) || (got.store_offset !== want.store_offset)
                || (got.store_len !== want.store_len) || (got.event_res !== want.event_res)
                || (got.bytes_received !== want.bytes_received)
                || (got.peer_port !== want.peer_port);
            if (bad) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    trr_in_if  in_ch ();
    trr_out_if out_ch ();
    trr_cfg_if cfg_ch ();

    tftp_read_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    transfer_scoreboard sb = new;

    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    bit          hold_req = 1'b0;
    int          sent_items = 0;
    logic [31:0] remote = '0;

    always #6 i_clk = ~i_clk;

    function automatic int draw_gap(bit enable);
        return enable ? $urandom_range(0, 7) : 0;
    endfunction

    function automatic t_rx_item make_item(logic req, logic [31:0] addr, logic [15:0] port,
                                           logic [15:0] len, logic [15:0] op,
                                           logic [15:0] blk);
        t_rx_item it;
        it.req_type = req;
        it.src_addr = addr;
        it.src_port = port;
        it.datagram_len = len;
        it.opcode = op;
        it.block_number = blk;
        return it;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_item(t_rx_item it);
        int gap;
        gap = draw_gap(send_idle);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= it.req_type;
        in_ch.src_addr <= it.src_addr;
        in_ch.src_port <= it.src_port;
        in_ch.datagram_len <= it.datagram_len;
        in_ch.opcode <= it.opcode;
        in_ch.block_number <= it.block_number;
        do @(negedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(it);
        sent_items++;
        @(posedge i_clk);
    endtask

    task automatic send_start();
        send_item(make_item(1'b0, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom)));
    endtask

    task automatic send_dgram(logic [31:0] addr, logic [15:0] port, logic [15:0] len,
                              logic [15:0] op, logic [15:0] blk);
        send_item(make_item(1'b1, addr, port, len, op, blk));
    endtask

    // Stop offering items until every predicted result has been seen.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic write_reg(trr_pkg::t_cfg_reg idx, logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= idx;
        cfg_ch.data <= data;
        do @(negedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.set_reg(idx, data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_setup(int sel);
        logic [31:0] bsize;
        case (sel % 4)
            0: begin
                remote = '0;
                write_reg(trr_pkg::CFG_SERVER_PORT, 32'd0);
                bsize = $urandom_range(0, 3000);
            end
            1: begin
                remote = '1;
                write_reg(trr_pkg::CFG_SERVER_PORT, 32'h0000_FFFF);
                bsize = '1;
            end
            default: begin
                remote = $urandom;
                write_reg(trr_pkg::CFG_SERVER_PORT, $urandom_range(0, 65535));
                bsize = $urandom_range(0, 20000);
            end
        endcase
        write_reg(trr_pkg::CFG_REMOTE_ADDR, remote);
        write_reg(trr_pkg::CFG_BUFFER_SIZE, bsize);
    endtask

    // One transfer: mostly in-sequence blocks, with duplicates, strays and noise mixed in.
    task automatic random_transfer(int min_n);
        logic [15:0] port;
        logic [15:0] blk;
        int          n;
        int          pick;
        t_rx_item    it;
        port = 16'($urandom);
        blk = 16'd1;
        n = $urandom_range(min_n, 12);
        send_start();
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            it = make_item(1'b1, remote, port, 16'd516, trr_pkg::OP_DATA, blk);
            if (pick < 70) begin
                if (k == n - 1)
                    it.datagram_len = 16'($urandom_range(4, 515));
                else if ($urandom_range(0, 7) == 0)
                    it.datagram_len = 16'($urandom_range(516, 65535));
                blk++;
            end else if (pick < 76) begin
                it.block_number = blk - 16'd1;
            end else if (pick < 80) begin
                it.src_addr = remote ^ (32'd1 << $urandom_range(0, 31));
            end else if (pick < 84) begin
                it.src_port = port ^ (16'd1 << $urandom_range(0, 15));
            end else if (pick < 88) begin
                it.datagram_len = 16'($urandom_range(0, 3));
            end else if (pick < 92) begin
                it.opcode = 16'($urandom);
            end else if (pick < 94) begin
                it.opcode = trr_pkg::OP_ERROR;
            end else if (pick < 97) begin
                it.block_number = 16'($urandom);
            end else begin
                it = make_item(1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom));
            end
            send_item(it);
        end
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial begin : result_sink
        int               stall;
        trr_pkg::t_result got;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_gap(recv_idle);
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(negedge i_clk); while (out_ch.valid !== 1'b1);
            got.send_request = out_ch.send_request;
            got.send_ack = out_ch.send_ack;
            got.ack_block = out_ch.ack_block;
            got.store_offset = out_ch.store_offset;
            got.store_len = out_ch.store_len;
            got.event_res = trr_pkg::t_event'(out_ch.event_res);
            got.bytes_received = out_ch.bytes_received;
            got.peer_port = out_ch.peer_port;
            sb.check_result(got);
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [31:0] r;
        logic [15:0] p;
        int          phase_no;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.req_type <= 1'b0;
        in_ch.src_addr <= '0;
        in_ch.src_port <= '0;
        in_ch.datagram_len <= '0;
        in_ch.opcode <= '0;
        in_ch.block_number <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.addr <= trr_pkg::CFG_REMOTE_ADDR;
        cfg_ch.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        r = 32'hC0A8_0A01;
        p = 16'h8001;
        remote = r;
        write_reg(trr_pkg::CFG_REMOTE_ADDR, r);
        write_reg(trr_pkg::CFG_SERVER_PORT, 32'd69);
        write_reg(trr_pkg::CFG_BUFFER_SIZE, 32'd2000);
        send_dgram(r, p, 16'd516, trr_pkg::OP_DATA, 16'd1);          // idle: dropped
        send_start();
        send_dgram(~r, p, 16'd516, trr_pkg::OP_DATA, 16'd1);         // foreign host
        send_dgram(r, p, 16'd0, trr_pkg::OP_DATA, 16'd1);            // runt, but port latches
        send_dgram(r, ~p, 16'd516, trr_pkg::OP_DATA, 16'd1);         // wrong port
        send_dgram(r, p, 16'd516, trr_pkg::OP_DATA, 16'd1);
        send_dgram(r, p, 16'd516, trr_pkg::OP_DATA, 16'd1);          // duplicate
        send_dgram(r, p, 16'd516, trr_pkg::OP_DATA, 16'hFFFF);       // out of sequence
        send_dgram(r, p, 16'd516, 16'hFFFF, 16'd2);
        send_dgram(r, p, 16'd516, 16'd0, 16'd2);
        send_dgram(r, p, 16'd516, trr_pkg::OP_DATA, 16'd2);
        send_dgram(r, p, 16'hFFFF, trr_pkg::OP_DATA, 16'd3);         // clipped by buffer
        send_dgram(r, p, 16'd516, trr_pkg::OP_DATA, 16'd4);          // after overflow: dropped
        send_start();
        send_dgram(r, 16'h0000, 16'd516, trr_pkg::OP_DATA, 16'd0);   // block 0 re-ACKed
        send_dgram(r, 16'h0000, 16'd4, trr_pkg::OP_DATA, 16'd1);     // empty last block
        send_start();
        send_dgram(r, 16'hFFFF, 16'd3, trr_pkg::OP_ERROR, 16'd0);
        send_dgram(r, 16'hFFFF, 16'd5, trr_pkg::OP_ERROR, 16'd1);
        send_start();
        send_start();
        send_dgram(r, p, 16'd100, trr_pkg::OP_DATA, 16'd1);
        send_start();
        send_dgram(r, p, 16'd516, trr_pkg::OP_DATA, 16'd1);
        drain();
        // shrink the buffer below what is already stored
        write_reg(trr_pkg::CFG_BUFFER_SIZE, 32'd100);
        send_dgram(r, p, 16'd516, trr_pkg::OP_DATA, 16'd2);
        drain();
        write_reg(trr_pkg::CFG_BUFFER_SIZE, 32'd0);
        send_start();
        send_dgram(r, p, 16'd4, trr_pkg::OP_DATA, 16'd1);
        send_start();
        send_dgram(r, p, 16'd5, trr_pkg::OP_DATA, 16'd1);
        drain();

        phase_no = 0;
        while (sent_items < TOTAL_ITEMS) begin
            if (phase_no % 3 == 0) begin
                drain();
                random_setup(phase_no / 3);
            end
            send_idle = ($urandom_range(0, 4) != 0);
            recv_idle = ($urandom_range(0, 4) != 0);
            if (phase_no == 5) begin
                // back up the result side while items keep coming
                send_idle = 1'b0;
                hold_req = 1'b1;
                random_transfer(8);
            end else begin
                random_transfer(1);
            end
            phase_no++;
        end
        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin : watchdog
        #(2_000_000);
        $display("testbench NOT OK");
        $finish;
    end

endmodule
